// ===== src/tbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbm_pkg
// shared constants, command codes and controller/datapath interface types
// for the countdown timer bank
// ----------------------------------------------------------------------------
package tbm_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 32;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int PTR_W      = $clog2(NUM_TIMERS + 1);

    // fixed field widths of the stream words
    localparam int FUNC_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int FIELD_T_W  = 32;
    localparam int MODE_W     = 2;
    localparam int COND_W     = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_ADD        = 3'd1,
        FN_STOP       = 3'd2,
        FN_PAUSE      = 3'd3,
        FN_RESUME     = 3'd4,
        FN_PAUSE_ALL  = 3'd5,
        FN_RESUME_ALL = 3'd6,
        FN_CLEAR      = 3'd7
    } t_func;

    localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COND    = 2'd2;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input word
        logic exec;        // apply the captured command, latch ok
        logic rd_issue;    // read stores at the addressed slot
        logic resume_wr;   // reload remaining from the read interval
        logic scan_start;  // reset the slot sweep
        logic scan_run;    // sweep in progress
        logic push_ack;    // send the acknowledge word
        logic push_flush;  // send the held expiry with last set
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  delta_zero;
        logic  ok;
        logic  out_free;
        logic  scan_done;
        logic  pend_valid;
    } t_dp_stat;

endpackage

// ===== src/tbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbm_ctrl
// command sequencer: decodes the captured command and steps the datapath
// ----------------------------------------------------------------------------
module tbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output tbm_pkg::t_dp_cmd  o_cmd,
    input  tbm_pkg::t_dp_stat i_stat
);
    import tbm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESUME,
        ST_SCAN,
        ST_ACK,
        ST_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.func)
                    FN_TICK: begin
                        if (i_stat.delta_zero) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                    end
                    FN_RESUME_ALL: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                    FN_RESUME: begin
                        o_cmd.rd_issue = i_stat.ok;
                        n_state        = i_stat.ok ? ST_RESUME : ST_ACK;
                    end
                    default: begin
                        n_state = ST_ACK;
                    end
                endcase
            end
            ST_RESUME: begin
                o_cmd.resume_wr = 1'b1;
                n_state         = ST_ACK;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.func != FN_TICK) begin
                        n_state = ST_ACK;
                    end else if (i_stat.pend_valid) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.push_ack = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push_flush = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tbm_dp.sv =====
// ----------------------------------------------------------------------------
// tbm_dp
// timer stores, slot flags, countdown sweep and the output word register
// ----------------------------------------------------------------------------
module tbm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tbm_pkg::t_dp_cmd                    i_cmd,
    output tbm_pkg::t_dp_stat                   o_stat,
    input  logic [tbm_pkg::FUNC_W-1:0]          i_func,
    input  logic [tbm_pkg::SLOT_W-1:0]          i_slot,
    input  logic [tbm_pkg::FIELD_T_W-1:0]       i_interval,
    input  logic [tbm_pkg::MODE_W-1:0]          i_mode,
    input  logic [tbm_pkg::FIELD_T_W-1:0]       i_delta,
    input  logic [tbm_pkg::COND_W-1:0]          i_cond,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_out_kind,
    output logic                                o_out_ok,
    output logic [tbm_pkg::SLOT_W-1:0]          o_out_slot,
    output logic                                o_out_last
);
    import tbm_pkg::*;

    // captured command word
    t_func                 r_func;
    logic [SLOT_W-1:0]     r_slot;
    logic [TIME_WIDTH-1:0] r_interval;
    logic [MODE_W-1:0]     r_mode;
    logic [TIME_WIDTH-1:0] r_delta;
    logic [COND_W-1:0]     r_cond;
    logic                  r_ok;

    // stores
    logic [TIME_WIDTH-1:0] r_mem_interval  [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] r_mem_remaining [NUM_TIMERS];
    logic [MODE_W-1:0]     r_mem_mode      [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] r_rd_interval;
    logic [TIME_WIDTH-1:0] r_rd_remaining;
    logic [MODE_W-1:0]     r_rd_mode;

    logic [NUM_TIMERS-1:0] r_active;
    logic [NUM_TIMERS-1:0] r_registered;
    logic [NUM_TIMERS-1:0] n_active;
    logic [NUM_TIMERS-1:0] n_registered;

    // sweep
    logic [PTR_W-1:0]      r_ptr;
    logic                  r_proc_v;
    logic [IDX_W-1:0]      r_proc_slot;
    logic                  r_pend_v;
    logic [IDX_W-1:0]      r_pend_slot;

    // output word
    logic                  r_out_v;
    logic                  r_out_kind;
    logic                  r_out_ok;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_last;

    logic [IDX_W-1:0]      slot_idx;
    logic                  in_range;
    logic                  slot_reg;
    logic                  cmd_ok;
    logic                  out_free;
    logic [NUM_TIMERS-1:0] cond_ext;
    logic                  is_tick;
    logic [TIME_WIDTH-1:0] rem_after;
    logic                  proc_act;
    logic                  proc_fire;
    logic                  stall;
    logic                  adv;
    logic                  issue;
    logic                  proc_step;
    logic                  scan_push;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic                  add_we;
    logic                  rem_we;
    logic [IDX_W-1:0]      rem_waddr;
    logic [TIME_WIDTH-1:0] rem_wdata;
    logic                  ack_has_slot;

    assign slot_idx = IDX_W'(r_slot);
    assign in_range = (32'(r_slot) < NUM_TIMERS);
    assign slot_reg = r_registered[slot_idx];
    assign out_free = !r_out_v || i_out_ready;
    assign cond_ext = NUM_TIMERS'(r_cond);
    assign is_tick  = (r_func == FN_TICK);

    always_comb begin
        case (r_func)
            FN_ADD:                       cmd_ok = in_range;
            FN_STOP, FN_PAUSE, FN_RESUME: cmd_ok = in_range && slot_reg;
            default:                      cmd_ok = 1'b1;
        endcase
    end

    // sweep stage
    assign rem_after = (r_rd_remaining > r_delta) ? (r_rd_remaining - r_delta)
                                                  : '0;
    assign proc_act  = r_active[r_proc_slot];
    assign proc_fire = r_proc_v && is_tick && proc_act && (rem_after == '0) &&
                       ((r_rd_mode != MODE_COND) || cond_ext[r_proc_slot]);
    assign stall     = proc_fire && r_pend_v && !out_free;
    assign adv       = i_cmd.scan_run && !stall;
    assign issue     = adv && (r_ptr < PTR_W'(NUM_TIMERS));
    assign proc_step = adv && r_proc_v;
    assign scan_push = proc_step && proc_fire && r_pend_v;

    assign rd_addr = i_cmd.rd_issue ? slot_idx : r_ptr[IDX_W-1:0];
    assign rd_en   = i_cmd.rd_issue || issue;
    assign add_we  = i_cmd.exec && (r_func == FN_ADD) && in_range;

    // remaining store write port
    always_comb begin
        rem_we    = 1'b0;
        rem_waddr = slot_idx;
        rem_wdata = r_interval;
        if (add_we) begin
            rem_we = 1'b1;
        end else if (i_cmd.resume_wr) begin
            rem_we    = 1'b1;
            rem_wdata = r_rd_interval;
        end else if (proc_step) begin
            rem_waddr = r_proc_slot;
            if (is_tick) begin
                rem_we    = proc_act;
                rem_wdata = (proc_fire && (r_rd_mode == MODE_REPEAT)) ? r_rd_interval
                                                                      : rem_after;
            end else begin
                rem_we    = r_registered[r_proc_slot];
                rem_wdata = r_rd_interval;
            end
        end
    end

    // slot flags
    always_comb begin
        n_active     = r_active;
        n_registered = r_registered;
        if (i_cmd.exec) begin
            case (r_func)
                FN_ADD: begin
                    if (in_range) begin
                        n_active[slot_idx]     = 1'b1;
                        n_registered[slot_idx] = 1'b1;
                    end
                end
                FN_STOP: begin
                    if (cmd_ok) begin
                        n_active[slot_idx]     = 1'b0;
                        n_registered[slot_idx] = 1'b0;
                    end
                end
                FN_PAUSE: begin
                    if (cmd_ok) begin
                        n_active[slot_idx] = 1'b0;
                    end
                end
                FN_PAUSE_ALL:  n_active = r_active & ~r_registered;
                FN_RESUME_ALL: n_active = r_active | r_registered;
                FN_CLEAR: begin
                    n_active     = '0;
                    n_registered = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.resume_wr) begin
            n_active[slot_idx] = 1'b1;
        end
        if (proc_step && proc_fire && (r_rd_mode != MODE_REPEAT)) begin
            n_active[r_proc_slot]     = 1'b0;
            n_registered[r_proc_slot] = 1'b0;
        end
    end

    // stores, written and read in clocked blocks
    always_ff @(posedge i_clk) begin
        if (add_we) begin
            r_mem_interval[slot_idx] <= r_interval;
            r_mem_mode[slot_idx]     <= r_mode;
        end
        if (rem_we) begin
            r_mem_remaining[rem_waddr] <= rem_wdata;
        end
        if (rd_en) begin
            r_rd_interval  <= r_mem_interval[rd_addr];
            r_rd_remaining <= r_mem_remaining[rd_addr];
            r_rd_mode      <= r_mem_mode[rd_addr];
        end
    end

    // captured word and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= t_func'(i_func);
            r_slot     <= i_slot;
            r_interval <= TIME_WIDTH'(i_interval);
            r_mode     <= i_mode;
            r_delta    <= TIME_WIDTH'(i_delta);
            r_cond     <= i_cond;
        end
        if (i_cmd.exec) begin
            r_ok <= cmd_ok;
        end
        if (issue) begin
            r_proc_slot <= r_ptr[IDX_W-1:0];
        end
        if (proc_step && proc_fire) begin
            r_pend_slot <= r_proc_slot;
        end
    end

    assign ack_has_slot = (r_func == FN_ADD) || (r_func == FN_STOP) ||
                          (r_func == FN_PAUSE) || (r_func == FN_RESUME);

    // control state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_registered <= '0;
            r_ptr        <= '0;
            r_proc_v     <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_registered <= n_registered;

            if (i_cmd.scan_start) begin
                r_ptr    <= '0;
                r_proc_v <= 1'b0;
                r_pend_v <= 1'b0;
            end else if (adv) begin
                r_proc_v <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + PTR_W'(1);
                end
                if (r_proc_v && proc_fire) begin
                    r_pend_v <= 1'b1;
                end
            end else if (i_cmd.push_flush) begin
                r_pend_v <= 1'b0;
            end

            if (scan_push || i_cmd.push_ack || i_cmd.push_flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_push || i_cmd.push_flush) begin
            r_out_kind <= KIND_EXPIRY;
            r_out_ok   <= 1'b1;
            r_out_slot <= SLOT_W'(r_pend_slot);
            r_out_last <= i_cmd.push_flush;
        end else if (i_cmd.push_ack) begin
            r_out_kind <= KIND_ACK;
            r_out_ok   <= r_ok;
            r_out_slot <= ack_has_slot ? r_slot : '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_kind  = r_out_kind;
    assign o_out_ok    = r_out_ok;
    assign o_out_slot  = r_out_slot;
    assign o_out_last  = r_out_last;

    assign o_stat.func       = r_func;
    assign o_stat.delta_zero = (r_delta == '0);
    assign o_stat.ok         = cmd_ok;
    assign o_stat.out_free   = out_free;
    assign o_stat.scan_done  = (r_ptr == PTR_W'(NUM_TIMERS)) && !r_proc_v;
    assign o_stat.pend_valid = r_pend_v;

    // a running timer is always a registered one
    a_active_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~r_registered) == '0)
        else $error("active timer without registration");

    // no word is loaded over one that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_push || i_cmd.push_ack || i_cmd.push_flush) |-> out_free)
        else $error("output word overwritten");

    // the sweep stage is only occupied during a sweep
    a_proc_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_proc_v |-> $past(i_cmd.scan_run))
        else $error("sweep stage valid outside a sweep");

    // the final expiry is only sent when one is held
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_flush |-> (r_pend_v && !i_cmd.scan_run))
        else $error("flush without a held expiry");

endmodule

// ===== src/timer_bank_with_modes.sv =====
// ----------------------------------------------------------------------------
// timer_bank_with_modes
// bank of countdown timers with oneshot, repeating and conditional modes
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                     | contents
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser func, tdata command fields
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser kind, tdata ok+slot, tlast
//
//  command: capture, execute and acknowledge; a resume reloads before the acknowledge
//  tick or resume all: one slot a cycle while the sweep is not held, then
//  the final expiry, if one is held, or the acknowledge; a zero delta tick sends no word
//  reset clears the slot flags, so every timer comes up unregistered
//  a stalled m_axis holds the final word, and holds the sweep when a further
//  expiry is found while the output word still waits
// ----------------------------------------------------------------------------
module timer_bank_with_modes (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], interval[35:4], mode[37:36], delta[69:38],
    // condition_mask[85:70], zero fill[87:86]
    input  logic [tbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func[2:0]
    input  logic [tbm_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ok[0], fired_slot[4:1], zero fill[7:5]
    output logic [tbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import tbm_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic              out_ok;
    logic [SLOT_W-1:0] out_slot;

    // sequencer: accepts a word only when the previous one is fully handled
    tbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // stores, flags, sweep and output word register
    tbm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (s_axis_tuser),
        .i_slot      (s_axis_tdata[3:0]),
        .i_interval  (s_axis_tdata[35:4]),
        .i_mode      (s_axis_tdata[37:36]),
        .i_delta     (s_axis_tdata[69:38]),
        .i_cond      (s_axis_tdata[85:70]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_ok    (out_ok),
        .o_out_slot  (out_slot),
        .o_out_last  (m_axis_tlast)
    );

    // pack the result word, ok in the lowest bit
    assign m_axis_tdata = {3'b000, out_slot, out_ok};

endmodule
